/* hdl/vda_pkg.sv */
// ----------------------------------------------------------------------------
// vda_pkg
// Shared types and constants of the vector distance accumulator.
// ----------------------------------------------------------------------------
package vda_pkg;

	localparam int SUM_BITS  = 42;
	localparam int ROOT_BITS = SUM_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 1;
	localparam int STEP_BITS = $clog2(ROOT_BITS);
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	typedef enum logic [1:0] {
		MODE_SQ   = 2'd0,
		MODE_EUCL = 2'd1,
		MODE_L1   = 2'd2,
		MODE_MAX  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROOT,
		B_DONE
	} back_state_t;

	// one finished vector sum waiting for the back part
	typedef struct packed {
		logic [SUM_BITS-1:0] sum;
		logic                root;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

/* hdl/vda_front.sv */
// ----------------------------------------------------------------------------
// vda_front
// Takes coordinate pairs, forms the per-mode term and keeps the running sum.
// ----------------------------------------------------------------------------
module vda_front import vda_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [COORD_BITS-1:0] x_coord,
	input  logic [COORD_BITS-1:0] y_coord,
	input  logic                  last_element,
	input  mode_t                 mode,
	output logic [1:0]            inflight,
	output push_t                 push_out
);

	localparam int SQ_BITS = (COORD_BITS < ROOT_BITS) ? COORD_BITS : ROOT_BITS;

	logic [COORD_BITS:0]   diff;
	logic [COORD_BITS:0]   mag;
	logic [COORD_BITS-1:0] abs_d;

	logic                  v_s1;
	logic [COORD_BITS-1:0] d_s1;
	mode_t                 mode_s1;
	logic                  last_s1;

	logic                  v_s2;
	logic [SUM_BITS-1:0]   term_s2;
	mode_t                 mode_s2;
	logic                  last_s2;

	logic [SQ_BITS-1:0]    sq_in;
	logic [2*SQ_BITS-1:0]  prod;
	logic                  big;
	logic [SUM_BITS-1:0]   term;

	logic [SUM_BITS:0]     sum_wide;
	logic [SUM_BITS-1:0]   sum_next;
	logic [SUM_BITS-1:0]   running_sum_q;

	// magnitude of the difference always fits in COORD_BITS
	always_comb begin
		diff  = {x_coord[COORD_BITS-1], x_coord} - {y_coord[COORD_BITS-1], y_coord};
		mag   = diff[COORD_BITS] ? ((COORD_BITS+1)'(0) - diff) : diff;
		abs_d = mag[COORD_BITS-1:0];
	end

	// squares of differences at or above 2^ROOT_BITS overflow the sum anyway
	always_comb begin
		sq_in = d_s1[SQ_BITS-1:0];
		prod  = sq_in * sq_in;
		big   = (d_s1 >> SQ_BITS) != '0;
		case (mode_s1)
			MODE_SQ, MODE_EUCL: term = big ? SUM_MAX : SUM_BITS'(prod);
			default:            term = SUM_BITS'(d_s1);
		endcase
	end

	always_comb begin
		sum_wide = {1'b0, running_sum_q} + {1'b0, term_s2};
		case (mode_s2)
			MODE_MAX: sum_next = (term_s2 > running_sum_q) ? term_s2 : running_sum_q;
			default:  sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			running_sum_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (v_s2) begin
				running_sum_q <= last_s2 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1    <= abs_d;
			mode_s1 <= mode;
			last_s1 <= last_element;
		end
		if (v_s1) begin
			term_s2 <= term;
			mode_s2 <= mode_s1;
			last_s2 <= last_s1;
		end
	end

	assign inflight             = {1'b0, v_s1} + {1'b0, v_s2};
	assign push_out.valid       = v_s2 && last_s2;
	assign push_out.entry.sum   = sum_next;
	assign push_out.entry.root  = (mode_s2 == MODE_EUCL);

endmodule

/* hdl/vda_queue.sv */
// ----------------------------------------------------------------------------
// vda_queue
// Short queue of finished sums between the front and back parts.
// ----------------------------------------------------------------------------
module vda_queue import vda_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  push_t                push_in,
	input  logic                 pop_req,
	output entry_t               head,
	output logic                 q_valid,
	output logic [QCNT_BITS-1:0] count
);

	entry_t               store_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_pop;

	assign do_pop  = pop_req && (count_q != '0);
	assign head    = store_q[rd_ptr_q];
	assign q_valid = (count_q != '0);
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_in.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_in.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_in.valid) begin
			store_q[wr_ptr_q] <= push_in.entry;
		end
	end

endmodule

/* hdl/vda_back.sv */
// ----------------------------------------------------------------------------
// vda_back
// Takes finished sums, runs the bit-pair square root where needed and
// holds the result register.
// ----------------------------------------------------------------------------
module vda_back import vda_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  entry_t              head,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic [SUM_BITS-1:0] distance
);

	back_state_t          state_q;
	back_state_t          state_d;
	logic                 start;
	logic                 direct;
	logic                 finish;
	logic                 out_free;

	logic                 out_v_q;
	logic [SUM_BITS-1:0]  out_q;
	logic [SUM_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [STEP_BITS-1:0] step_q;

	logic [REM_BITS+1:0]  rem_cat;
	logic [REM_BITS+1:0]  trial;
	logic [REM_BITS+1:0]  rem_sub;
	logic                 ge;
	logic [REM_BITS-1:0]  rem_new;
	logic [ROOT_BITS-1:0] root_new;

	assign out_free = !out_v_q || pop;

	// one result bit per step, two radicand bits brought down each time
	always_comb begin
		rem_cat  = {rem_q, rad_q[SUM_BITS-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		rem_sub  = rem_cat - trial;
		ge       = (rem_cat >= trial);
		rem_new  = ge ? rem_sub[REM_BITS-1:0] : rem_cat[REM_BITS-1:0];
		root_new = {root_q[ROOT_BITS-2:0], ge};
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		start   = 1'b0;
		direct  = 1'b0;
		finish  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid && head.root) begin
					q_pop   = 1'b1;
					start   = 1'b1;
					state_d = B_ROOT;
				end else if (q_valid && out_free) begin
					q_pop  = 1'b1;
					direct = 1'b1;
				end
			end
			B_ROOT: begin
				if (step_q == STEP_BITS'(ROOT_BITS - 1)) begin
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (direct || finish) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (start) begin
				step_q <= '0;
			end else if (state_q == B_ROOT) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= head.sum;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == B_ROOT) begin
			rad_q  <= rad_q << 2;
			rem_q  <= rem_new;
			root_q <= root_new;
		end
		if (direct) begin
			out_q <= head.sum;
		end else if (finish) begin
			out_q <= SUM_BITS'(root_q);
		end
	end

	assign empty    = !out_v_q;
	assign distance = out_q;

endmodule

/* hdl/vector_distance_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// vector_distance_accumulator_unit
// Streams coordinate pairs and gives the distance of each vector pair in
// squared euclidean, euclidean, L1 or maximum-difference mode.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  input    | push / full      | x_coord, y_coord, last_element
//  result   | pop / empty      | distance
//  config   | cfg_we           | cfg_data (distance mode)
//
//  one coordinate pair per cycle while full is low; a sum passes the front
//  stages s1 and s2 into the queue and from there into the result register.
//  the back part drains one sum per cycle while results are popped, but in
//  euclidean mode the 21-step shared square root unit must finish first.
//  full rises while queued sums plus pairs in flight fill the 4-entry queue.
//  reset clears the running sum, the queue and the result register; mode 0.
// ----------------------------------------------------------------------------
module vector_distance_accumulator_unit import vda_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [COORD_BITS-1:0] x_coord,
	input  logic [COORD_BITS-1:0] y_coord,
	input  logic                  last_element,
	input  logic                  pop,
	output logic                  empty,
	output logic [SUM_BITS-1:0]   distance
);

	mode_t                mode_q;
	logic                 accept;
	logic [1:0]           inflight;
	push_t                push_fq;
	entry_t               head;
	logic                 q_valid;
	logic                 q_pop;
	logic [QCNT_BITS-1:0] q_count;
	logic [QCNT_BITS:0]   pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SQ;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// reserve queue room for every pair still in the front pipeline
	assign pending = {1'b0, q_count} + (QCNT_BITS+1)'(inflight);
	assign full    = (pending >= (QCNT_BITS+1)'(QDEPTH));
	assign accept  = push && !full;

	vda_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.last_element(last_element),
		.mode        (mode_q),
		.inflight    (inflight),
		.push_out    (push_fq)
	);

	vda_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_in(push_fq),
		.pop_req(q_pop),
		.head   (head),
		.q_valid(q_valid),
		.count  (q_count)
	);

	vda_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.distance(distance)
	);

endmodule

/* hdl/vda_checker.sv */
// ----------------------------------------------------------------------------
// vda_checker
// Port-level checks of the vector distance accumulator, bound to the top.
// ----------------------------------------------------------------------------
module vda_checker import vda_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [1:0]            cfg_data,
	input logic                  push,
	input logic                  full,
	input logic [COORD_BITS-1:0] x_coord,
	input logic [COORD_BITS-1:0] y_coord,
	input logic                  last_element,
	input logic                  pop,
	input logic                  empty,
	input logic [SUM_BITS-1:0]   distance
);

	mode_t      mode_q;
	logic [3:0] lasts_q;
	logic       in_last;
	logic       out_xfer;

	assign in_last  = push && !full && last_element;
	assign out_xfer = pop && !empty;

	// results owed: closed vectors not yet transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SQ;
			lasts_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_data);
			end
			case ({in_last, out_xfer})
				2'b10:   lasts_q <= lasts_q + 1'b1;
				2'b01:   lasts_q <= lasts_q - 1'b1;
				default: lasts_q <= lasts_q;
			endcase
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(distance))
		else $error("result changed while stalled");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (lasts_q != '0))
		else $error("result without a closed vector");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mode_q == MODE_EUCL) |-> ((distance >> ROOT_BITS) == '0))
		else $error("square root wider than half the sum");

endmodule

bind vector_distance_accumulator_unit vda_checker #(
	.COORD_BITS(COORD_BITS)
) u_vda_checker (.*);

/* bench/vector_distance_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_distance_check
// Watches the coordinate and distance channels of the accumulator. It keeps
// its own running sum and mode, works out every distance the block owes, and
// compares each popped distance with the oldest one owed.
// ----------------------------------------------------------------------------
module vector_distance_check import vda_pkg::*; #(
	parameter int COORD_W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_data,
	input  logic                push,
	input  logic                full,
	input  logic [COORD_W-1:0]  x_coord,
	input  logic [COORD_W-1:0]  y_coord,
	input  logic                last_element,
	input  logic                pop,
	input  logic                empty,
	input  logic [SUM_BITS-1:0] distance,
	output int                  due_count,
	output int                  mismatches,
	output int                  distances_seen
);

	mode_t               cur_mode;
	logic [SUM_BITS-1:0] acc;
	logic [SUM_BITS-1:0] distance_due[$];
	logic [SUM_BITS-1:0] want;
	logic [SUM_BITS-1:0] gap;

	function automatic logic [SUM_BITS-1:0] abs_gap(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        m;
		d = $signed(a) - $signed(b);
		m = (d < 0) ? -d : d;
		return SUM_BITS'(m);
	endfunction

	function automatic logic [SUM_BITS-1:0] clip_add(input logic [SUM_BITS-1:0] a,
		input logic [SUM_BITS-1:0] b);
		logic [SUM_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
	endfunction

	// largest r with r*r <= v, one bit at a time from the top
	function automatic logic [SUM_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int b = ROOT_BITS - 1; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= 64'(v))
				r = t;
		end
		return SUM_BITS'(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_SQ;
			acc = '0;
			distance_due.delete();
			due_count = 0;
			mismatches = 0;
			distances_seen = 0;
		end else begin
			if (pop && !empty) begin
				distances_seen++;
				if (distance_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected distance %0d with none pending", distance);
				end else begin
					want = distance_due.pop_front();
					if (distance !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("distance mismatch: expected %0d got %0d", want, distance);
					end
				end
			end
			if (push && !full) begin
				gap = abs_gap(x_coord, y_coord);
				case (cur_mode)
					MODE_SQ, MODE_EUCL: acc = clip_add(acc, gap * gap);
					MODE_L1: acc = clip_add(acc, gap);
					default: begin
						if (gap > acc)
							acc = gap;
					end
				endcase
				if (last_element) begin
					distance_due.push_back((cur_mode == MODE_EUCL) ? floor_root(acc) : acc);
					acc = '0;
				end
			end
			if (cfg_we)
				cur_mode = mode_t'(cfg_data);
			due_count = distance_due.size();
		end
	end

endmodule

/* bench/vector_distance_accumulator_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_distance_accumulator_unit_test
// Streams coordinate pairs through the accumulator in all four distance
// modes: directed extremes, a mode change inside one vector, a saturating
// vector under the root, then random vectors with random gaps on both
// channels.
// ----------------------------------------------------------------------------
module vector_distance_accumulator_unit_test;
	import vda_pkg::*;

	localparam int COORD_W       = 16;
	localparam int RANDOM_PAIRS  = 680;
	localparam int SETTLE_CYCLES = 32;
	localparam int SAT_LEN       = 1030;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_data;
	logic                push;
	logic                full;
	logic [COORD_W-1:0]  x_coord;
	logic [COORD_W-1:0]  y_coord;
	logic                last_element;
	logic                pop;
	logic                empty;
	logic [SUM_BITS-1:0] distance;

	int due_count;
	int mismatches;
	int distances_seen;
	int pairs_sent;
	int mode_writes;
	bit tx_burst;
	bit rx_burst;
	int pop_hold;
	int hold_draw;

	vector_distance_accumulator_unit #(
		.COORD_BITS(COORD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.last_element(last_element),
		.pop(pop),
		.empty(empty),
		.distance(distance)
	);

	vector_distance_check #(
		.COORD_W(COORD_W)
	) check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.last_element(last_element),
		.pop(pop),
		.empty(empty),
		.distance(distance),
		.due_count(due_count),
		.mismatches(mismatches),
		.distances_seen(distances_seen)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: after each transfer hold pop low for a drawn number of cycles
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_hold <= 0;
		end else if (pop && !empty) begin
			hold_draw = rx_burst ? 0 : $urandom_range(0, 11);
			if (hold_draw != 0) begin
				pop <= 1'b0;
				pop_hold <= hold_draw - 1;
			end
		end else if (!pop) begin
			if (pop_hold == 0)
				pop <= 1'b1;
			else
				pop_hold <= pop_hold - 1;
		end
	end

	function automatic logic [COORD_W-1:0] rand_coord();
		int v;
		case ($urandom_range(0, 5))
			0: return {1'b1, {(COORD_W-1){1'b0}}};
			1: return {1'b0, {(COORD_W-1){1'b1}}};
			2: begin
				v = int'($urandom_range(0, 32)) - 16;
				return COORD_W'(v);
			end
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send_pair(input logic [COORD_W-1:0] xv, input logic [COORD_W-1:0] yv,
		input logic lastv);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		x_coord <= xv;
		y_coord <= yv;
		last_element <= lastv;
		do @(posedge clk); while (full);
		pairs_sent++;
	endtask

	// wait until every owed distance is out and the pipe has gone quiet
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_writes++;
	endtask

	// full-scale differences until the running sum clips
	task automatic send_saturating_vector();
		for (int k = 0; k < SAT_LEN; k++) begin
			if (k % 2 == 0)
				send_pair(16'sh7fff, 16'sh8000, k == SAT_LEN - 1);
			else
				send_pair(16'sh8000, 16'sh7fff, k == SAT_LEN - 1);
		end
	endtask

	initial begin
		int    start_pairs;
		int    budget;
		int    len;
		int    phase;
		int    phase_pairs;
		mode_t m;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		push = 1'b0;
		x_coord = '0;
		y_coord = '0;
		last_element = 1'b0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		pairs_sent = 0;
		mode_writes = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// squared euclidean out of reset: vectors at the extremes, single-pair and one of three pairs
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
		send_pair(16'shffff, 16'shffff, 1'b0);
		send_pair(16'sh0005, 16'shfffd, 1'b0);
		send_pair(16'sh8000, 16'sh0000, 1'b1);

		set_mode(MODE_EUCL);
		send_pair(16'sh0003, 16'sh0000, 1'b0);
		send_pair(16'sh0000, 16'shfffc, 1'b1);
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sh0000, 16'sh0000, 1'b1);

		set_mode(MODE_L1);
		send_pair(16'sh8000, 16'sh7fff, 1'b0);
		send_pair(16'sh0064, 16'shff9c, 1'b0);
		send_pair(16'sh0001, 16'sh0001, 1'b1);

		set_mode(MODE_MAX);
		send_pair(16'sh000a, 16'shfffb, 1'b0);
		send_pair(16'sh8000, 16'sh7fff, 1'b0);
		send_pair(16'sh0000, 16'sh0003, 1'b1);
		send_pair(16'shfff9, 16'shfff9, 1'b1);

		// one vector spread over three modes, the sum carried across
		send_pair(16'sh0064, 16'sh0000, 1'b0);
		set_mode(MODE_L1);
		send_pair(16'sh0000, 16'sh0032, 1'b0);
		set_mode(MODE_EUCL);
		send_pair(16'sh0003, 16'sh0000, 1'b1);

		// clipping of the sum under the root
		tx_burst = 1'b1;
		set_mode(MODE_EUCL);
		send_saturating_vector();
		tx_burst = 1'b0;

		start_pairs = pairs_sent;
		phase = 0;
		while (pairs_sent - start_pairs < RANDOM_PAIRS) begin
			m = (phase < 4) ? mode_t'(phase) : mode_t'($urandom_range(0, 3));
			set_mode(m);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			budget = $urandom_range(20, 120);
			phase_pairs = 0;
			while (phase_pairs < budget) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					send_pair(rand_coord(), rand_coord(), k == len - 1);
				phase_pairs += len;
			end
			// sometimes leave a vector open so the next mode picks up its sum
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					send_pair(rand_coord(), rand_coord(), 1'b0);
			end
			phase++;
		end
		// close any open vector before the end
		send_pair(rand_coord(), rand_coord(), 1'b1);
		rx_burst = 1'b0;
		drain();

		$display("covered %0d coordinate pairs, %0d mode writes, %0d random phases",
			pairs_sent, mode_writes, phase);
		$display("compared %0d distances, %0d mismatches", distances_seen, mismatches);
		if (mismatches == 0 && due_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/vda_pkg.sv
hdl/vda_front.sv
hdl/vda_queue.sv
hdl/vda_back.sv
hdl/vector_distance_accumulator_unit.sv
hdl/vda_checker.sv
bench/vector_distance_check.sv
bench/vector_distance_accumulator_unit_test.sv
